// ===== sv/fsr_pkg.sv =====
`timescale 1ns / 1ps

package fsr_pkg;

  // Default output raster and tile geometry
  localparam int unsigned OUT_WIDTH_DEF   = 640;
  localparam int unsigned OUT_HEIGHT_DEF  = 480;
  localparam int unsigned TILE_SIZE       = 4;
  localparam int unsigned TILE_W          = 2;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Coordinates cover the largest output size plus one partial tile
  localparam int unsigned COORD_W = 11;
  // Signed window bounds
  localparam int unsigned BOUND_W = 13;

  // Field widths
  localparam int unsigned VID_W    = 10;
  localparam int unsigned STEP_W   = 12;
  localparam int unsigned YSTEP_W  = STEP_W - 1;
  localparam int unsigned FRAC_W   = 10;
  localparam int unsigned ORIGIN_W = 23;
  localparam int unsigned LINEW_W  = 12;
  localparam int unsigned INDEX_W  = 19;
  localparam int unsigned ADDR_W   = 24;
  localparam int unsigned PIX_W    = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 23;

  // Scaled source coordinate widths
  localparam int unsigned SROW_W = COORD_W + YSTEP_W - FRAC_W;
  localparam int unsigned SCOL_W = COORD_W + STEP_W - FRAC_W;

  // Reset values of the scale registers
  localparam logic [STEP_W-1:0] X_STEP_RST = STEP_W'(1024);
  localparam logic [STEP_W-1:0] Y_STEP_RST = STEP_W'(2048);

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_H_START  = 3'd0,
    CFG_H_END    = 3'd1,
    CFG_V_START  = 3'd2,
    CFG_V_END    = 3'd3,
    CFG_X_STEP   = 3'd4,
    CFG_Y_STEP   = 3'd5,
    CFG_ORIGIN   = 3'd6,
    CFG_LINE_W   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [VID_W-1:0]    h_video_start;
    logic [VID_W-1:0]    h_video_end;
    logic [VID_W-1:0]    v_video_start;
    logic [VID_W-1:0]    v_video_end;
    logic [STEP_W-1:0]   x_step;
    logic [STEP_W-1:0]   y_step_raw;
    logic [ORIGIN_W-1:0] fb_origin;
    logic [LINEW_W-1:0]  line_width;
  } cfg_t;

  typedef struct packed {
    op_e              opcode;
    logic [PIX_W-1:0] pixel_in;
  } in_word_t;

  typedef struct packed {
    logic [INDEX_W-1:0] dest_index;
    logic [ADDR_W-1:0]  src_address;
    logic               blank;
    logic [PIX_W-1:0]   texel_out;
    logic               frame_last;
  } out_word_t;

  // Fields that ride along the address pipeline unchanged
  typedef struct packed {
    logic [INDEX_W-1:0] dest_index;
    logic               blank;
    logic [PIX_W-1:0]   texel;
    logic               frame_last;
  } meta_t;

  // One classified position from front to back
  typedef struct packed {
    meta_t              meta;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } job_t;

endpackage

// ===== sv/fsr_queue.sv =====
`timescale 1ns / 1ps

module fsr_queue import fsr_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  job_t wr_data_i,
  output logic full_o,
  input  logic rd_i,
  output logic rd_valid_o,
  output job_t rd_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o     = (count_q == CNT_FULL);
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (rd_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (wr_i && !rd_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (!wr_i && rd_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("queue count exceeds depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> (!full_o || rd_i))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> rd_valid_o)
    else $error("queue read while empty");

  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_i && !rd_i) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("queue count did not follow write");
`endif

endmodule

// ===== sv/fsr_front.sv =====
`timescale 1ns / 1ps

module fsr_front import fsr_pkg::*; #(
  parameter int unsigned OUT_WIDTH  = OUT_WIDTH_DEF,
  parameter int unsigned OUT_HEIGHT = OUT_HEIGHT_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_word_t in_word_i,
  input  cfg_t     cfg_i,
  output logic     job_valid_o,
  output job_t     job_o
);

  localparam logic signed [BOUND_W-1:0] OUT_W_S = BOUND_W'(OUT_WIDTH);
  localparam logic signed [BOUND_W-1:0] OUT_H_S = BOUND_W'(OUT_HEIGHT);
  localparam logic [COORD_W-1:0] OUT_W_C  = COORD_W'(OUT_WIDTH);
  localparam logic [COORD_W-1:0] OUT_H_C  = COORD_W'(OUT_HEIGHT);
  localparam logic [COORD_W-1:0] TILE_C   = COORD_W'(TILE_SIZE);
  localparam logic [TILE_W-1:0]  TILE_MAX = TILE_W'(TILE_SIZE - 1);

  logic [COORD_W-1:0] row_base_q, col_base_q;
  logic [TILE_W-1:0]  row_in_q, col_in_q;
  logic [INDEX_W-1:0] count_q;
  logic               active_q;
  logic signed [BOUND_W-1:0] lo_x_q, hi_x_q, lo_y_q, hi_y_q;

  logic signed [BOUND_W-1:0] diff_x, diff_y, num_x, num_y, adj_x, adj_y;
  logic signed [BOUND_W-1:0] margin_x, margin_y;
  logic signed [BOUND_W-1:0] row_s, col_s;
  logic [COORD_W-1:0] row, col, col_base_nx, row_base_nx;
  logic col_wrap, row_wrap, tile_end, last, blank, is_start, is_adv;
  logic [PIX_W-1:0] texel;

  assign is_start = accept_i && (in_word_i.opcode == OP_START);
  assign is_adv   = accept_i && (in_word_i.opcode == OP_ADVANCE) && active_q;

  // Centered window margins, halved with truncation toward zero
  assign diff_x   = $signed(BOUND_W'(cfg_i.h_video_end)) - $signed(BOUND_W'(cfg_i.h_video_start));
  assign diff_y   = $signed(BOUND_W'(cfg_i.v_video_end)) - $signed(BOUND_W'(cfg_i.v_video_start));
  assign num_x    = OUT_W_S - diff_x;
  assign num_y    = OUT_H_S - diff_y;
  assign adj_x    = num_x + $signed({{(BOUND_W-1){1'b0}}, num_x[BOUND_W-1]});
  assign adj_y    = num_y + $signed({{(BOUND_W-1){1'b0}}, num_y[BOUND_W-1]});
  assign margin_x = adj_x >>> 1;
  assign margin_y = adj_y >>> 1;

  // Current position and window test
  assign row   = row_base_q + COORD_W'(row_in_q);
  assign col   = col_base_q + COORD_W'(col_in_q);
  assign row_s = $signed({{(BOUND_W-COORD_W){1'b0}}, row});
  assign col_s = $signed({{(BOUND_W-COORD_W){1'b0}}, col});
  assign blank = (row_s < lo_y_q) || (row_s > hi_y_q) ||
                 (col_s < lo_x_q) || (col_s > hi_x_q);

  // Texel: alpha forced, then {p[15], p[14:1]}
  assign texel = blank ? '0 : {1'b1, in_word_i.pixel_in[PIX_W-1], in_word_i.pixel_in[PIX_W-2:1]};

  // Scan order: columns in tile, rows in tile, tile columns, tile rows
  assign col_base_nx = col_base_q + TILE_C;
  assign row_base_nx = row_base_q + TILE_C;
  assign col_wrap    = (col_base_nx >= OUT_W_C);
  assign row_wrap    = (row_base_nx >= OUT_H_C);
  assign tile_end    = (col_in_q == TILE_MAX) && (row_in_q == TILE_MAX);
  assign last        = tile_end && col_wrap && row_wrap;

  assign job_valid_o          = is_adv;
  assign job_o.meta.dest_index = count_q;
  assign job_o.meta.blank      = blank;
  assign job_o.meta.texel      = texel;
  assign job_o.meta.frame_last = last;
  assign job_o.row             = row;
  assign job_o.col             = col;

  // Scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_base_q <= '0;
      col_base_q <= '0;
      row_in_q   <= '0;
      col_in_q   <= '0;
      count_q    <= '0;
      active_q   <= 1'b0;
      lo_x_q     <= '0;
      hi_x_q     <= OUT_W_S;
      lo_y_q     <= '0;
      hi_y_q     <= OUT_H_S;
    end else if (is_start) begin
      row_base_q <= '0;
      col_base_q <= '0;
      row_in_q   <= '0;
      col_in_q   <= '0;
      count_q    <= '0;
      active_q   <= (cfg_i.line_width != '0);
      lo_x_q     <= margin_x;
      hi_x_q     <= OUT_W_S - margin_x;
      lo_y_q     <= margin_y;
      hi_y_q     <= OUT_H_S - margin_y;
    end else if (is_adv) begin
      count_q  <= count_q + INDEX_W'(1);
      col_in_q <= (col_in_q == TILE_MAX) ? '0 : col_in_q + TILE_W'(1);
      if (col_in_q == TILE_MAX) begin
        row_in_q <= (row_in_q == TILE_MAX) ? '0 : row_in_q + TILE_W'(1);
      end
      if (tile_end) begin
        col_base_q <= col_wrap ? '0 : col_base_nx;
        if (col_wrap) begin
          row_base_q <= row_wrap ? '0 : row_base_nx;
        end
      end
      if (last) begin
        active_q <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/fsr_back.sv =====
`timescale 1ns / 1ps

module fsr_back import fsr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      job_valid_i,
  input  job_t      job_i,
  output logic      job_pop_o,
  input  logic      pop_i,
  output logic      empty_o,
  output out_word_t out_word_o
);

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  meta_t              meta1_q, meta2_q;
  logic [SROW_W-1:0]  src_row_q;
  logic [SCOL_W-1:0]  src_col_q;
  logic [ADDR_W-2:0]  lin_q;
  out_word_t          out_q;

  logic [COORD_W+YSTEP_W-1:0] prod_row;
  logic [COORD_W+STEP_W-1:0]  prod_col;
  logic [SROW_W+LINEW_W-1:0]  prod_lin;
  logic [ADDR_W-1:0]          sum_lin;
  logic [ADDR_W-1:0]          addr;

  // Stage enables: a stage moves when it is empty or its successor moves
  assign en3       = !v3_q || pop_i;
  assign en2       = !v2_q || en3;
  assign en1       = !v1_q || en2;
  assign job_pop_o = job_valid_i && en1;

  // Stage 1: scale to source coordinates
  assign prod_row = job_i.row * cfg_i.y_step_raw[STEP_W-1:1];
  assign prod_col = job_i.col * cfg_i.x_step;

  // Stage 2: linear source pixel index, kept modulo the address range
  assign prod_lin = src_row_q * cfg_i.line_width;
  assign sum_lin  = ADDR_W'(prod_lin) + ADDR_W'(src_col_q);

  // Stage 3: byte address of the halfword
  assign addr = ADDR_W'(cfg_i.fb_origin) + {lin_q, 1'b0};

  always_ff @(posedge clk_i) begin
    if (en1 && job_valid_i) begin
      src_row_q <= prod_row[COORD_W+YSTEP_W-1:FRAC_W];
      src_col_q <= prod_col[COORD_W+STEP_W-1:FRAC_W];
      meta1_q   <= job_i.meta;
    end
    if (en2 && v1_q) begin
      lin_q   <= sum_lin[ADDR_W-2:0];
      meta2_q <= meta1_q;
    end
    if (en3 && v2_q) begin
      out_q.dest_index  <= meta2_q.dest_index;
      out_q.src_address <= addr;
      out_q.blank       <= meta2_q.blank;
      out_q.texel_out   <= meta2_q.texel;
      out_q.frame_last  <= meta2_q.frame_last;
    end
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= job_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  assign empty_o    = !v3_q;
  assign out_word_o = out_q;

endmodule

// ===== sv/framebuffer_scale_window_retile.sv =====
`timescale 1ns / 1ps
// Tiled framebuffer rescaler with a centered blanking window.
// Input queue port: in_word_i (opcode, pixel_in) is taken on a clock edge
// with push high and full low. OP_START latches the window margins from the
// video start/end registers and rewinds the scan; it gives no word. Each
// OP_ADVANCE of an active frame gives one result word: destination index,
// source halfword byte address, blank flag, formatted texel and a last flag.
// Advances while no frame is active are taken and dropped.
// Result queue port: out_word_o holds the oldest result while empty is low;
// pop with empty low takes it.
// Config port: cfg_index_i/cfg_data_i written when cfg_valid_i and
// cfg_ready_o are high; ready is always high. Write only while idle.
// A taken advance word is written to the front queue, then passes through the
// scale multiply, line multiply-add and address add into the output
// register, where it shows on the port.
// Throughput: one word per cycle while full is low, set by the front scan update.
// When pop stays low, the 3-stage address pipeline (its last stage is the
// output register) holds, the front queue fills and full rises; nothing is lost.
// Reset: scan idle until a start word, scale registers at 1.0, queues empty.

module framebuffer_scale_window_retile import fsr_pkg::*; #(
  parameter int unsigned OUT_WIDTH   = OUT_WIDTH_DEF,
  parameter int unsigned OUT_HEIGHT  = OUT_HEIGHT_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  in_word_t              in_word_i,
  output logic                  empty,
  input  logic                  pop,
  output out_word_t             out_word_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg_q;
  logic accept;
  logic fr_valid, q_valid, q_pop;
  job_t fr_job, q_job;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.h_video_start <= '0;
      cfg_q.h_video_end   <= '0;
      cfg_q.v_video_start <= '0;
      cfg_q.v_video_end   <= '0;
      cfg_q.x_step        <= X_STEP_RST;
      cfg_q.y_step_raw    <= Y_STEP_RST;
      cfg_q.fb_origin     <= '0;
      cfg_q.line_width    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_H_START: cfg_q.h_video_start <= cfg_data_i[VID_W-1:0];
        CFG_H_END:   cfg_q.h_video_end   <= cfg_data_i[VID_W-1:0];
        CFG_V_START: cfg_q.v_video_start <= cfg_data_i[VID_W-1:0];
        CFG_V_END:   cfg_q.v_video_end   <= cfg_data_i[VID_W-1:0];
        CFG_X_STEP:  cfg_q.x_step        <= cfg_data_i[STEP_W-1:0];
        CFG_Y_STEP:  cfg_q.y_step_raw    <= cfg_data_i[STEP_W-1:0];
        CFG_ORIGIN:  cfg_q.fb_origin     <= cfg_data_i[ORIGIN_W-1:0];
        CFG_LINE_W:  cfg_q.line_width    <= cfg_data_i[LINEW_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: scan and classify
  fsr_front #(
    .OUT_WIDTH  (OUT_WIDTH),
    .OUT_HEIGHT (OUT_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_word_i   (in_word_i),
    .cfg_i       (cfg_q),
    .job_valid_o (fr_valid),
    .job_o       (fr_job)
  );

  // Decoupling queue
  fsr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (fr_valid),
    .wr_data_i  (fr_job),
    .full_o     (full),
    .rd_i       (q_pop),
    .rd_valid_o (q_valid),
    .rd_data_o  (q_job)
  );

  // Back: address pipeline and output register
  fsr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (q_valid),
    .job_i       (q_job),
    .job_pop_o   (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import fsr_pkg::*;

  localparam int FRAME_W         = OUT_WIDTH_DEF;
  localparam int FRAME_H         = OUT_HEIGHT_DEF;
  localparam int SETTLE_CYCLES   = 10;
  localparam int RANDOM_WORDS    = 1300;
  localparam int MAX_PRINTS      = 40;
  localparam longint CYCLE_LIMIT = 3_000_000;

  // Mirror of the scan counters and latched window
  typedef struct {
    logic [8:0]         tile_row;
    logic [9:0]         tile_col;
    logic [TILE_W-1:0]  row_in;
    logic [TILE_W-1:0]  col_in;
    logic [INDEX_W-1:0] count;
    bit                 active;
    int                 margin_x;
    int                 margin_y;
  } scan_t;

  // One line of the directed plan: a register write or an input word
  typedef struct {
    bit                    is_write;
    cfg_idx_e              reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    in_word_t              word;
    bit                    typed;      // expectation written out by hand
    bit                    typed_has;
    out_word_t             typed_res;
  } plan_row_t;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  push      = 1'b0;
  logic                  full;
  in_word_t              in_word   = '0;
  logic                  empty;
  logic                  pop       = 1'b0;
  out_word_t             out_word;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  cfg_t        regs;
  scan_t       scan;
  out_word_t   pending_positions[$];
  plan_row_t   plan[$];
  int          err_cnt     = 0;
  int          counted     = 0;
  int unsigned stall_left  = 0;
  longint      cycles      = 0;

  framebuffer_scale_window_retile dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_word_i   (in_word),
    .empty       (empty),
    .pop         (pop),
    .out_word_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d words outstanding", cycles,
               pending_positions.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    if (err_cnt < MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick(input int unsigned hi_v);
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return 0;
    if (r == 1) return hi_v;
    return $urandom_range(0, hi_v);
  endfunction

  function automatic in_word_t make_word(input op_e op, input logic [PIX_W-1:0] p);
    in_word_t w;
    w.opcode   = op;
    w.pixel_in = p;
    return w;
  endfunction

  function automatic void shadow_write(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_H_START: regs.h_video_start = d[VID_W-1:0];
      CFG_H_END:   regs.h_video_end   = d[VID_W-1:0];
      CFG_V_START: regs.v_video_start = d[VID_W-1:0];
      CFG_V_END:   regs.v_video_end   = d[VID_W-1:0];
      CFG_X_STEP:  regs.x_step        = d[STEP_W-1:0];
      CFG_Y_STEP:  regs.y_step_raw    = d[STEP_W-1:0];
      CFG_ORIGIN:  regs.fb_origin     = d[ORIGIN_W-1:0];
      CFG_LINE_W:  regs.line_width    = d[LINEW_W-1:0];
      default: ;
    endcase
  endfunction

  // Predict the word for one accepted input; returns 1 when a word results
  function automatic bit scan_position(input in_word_t w, output out_word_t r);
    int         row;
    int         col;
    int         dx;
    int         dy;
    logic [63:0] srow;
    logic [63:0] scol;
    logic [63:0] addr;
    bit         last;
    r = '0;
    if (w.opcode == OP_START) begin
      dx = int'(regs.h_video_end) - int'(regs.h_video_start);
      dy = int'(regs.v_video_end) - int'(regs.v_video_start);
      scan.margin_x = (FRAME_W - dx) / 2;
      scan.margin_y = (FRAME_H - dy) / 2;
      scan.tile_row = '0;
      scan.tile_col = '0;
      scan.row_in   = '0;
      scan.col_in   = '0;
      scan.count    = '0;
      scan.active   = (regs.line_width != '0);
      return 1'b0;
    end
    if (!scan.active) return 1'b0;

    row = int'(scan.tile_row) + int'(scan.row_in);
    col = int'(scan.tile_col) + int'(scan.col_in);
    r.blank = (row < scan.margin_y) || (row > FRAME_H - scan.margin_y) ||
              (col < scan.margin_x) || (col > FRAME_W - scan.margin_x);

    srow = (64'(row) * 64'(regs.y_step_raw >> 1)) >> FRAC_W;
    scol = (64'(col) * 64'(regs.x_step)) >> FRAC_W;
    addr = 64'(regs.fb_origin) + 64'd2 * (srow * 64'(regs.line_width) + scol);
    r.src_address = addr[ADDR_W-1:0];
    r.texel_out   = r.blank ? '0 : {1'b1, w.pixel_in[15], w.pixel_in[14:1]};
    r.dest_index  = scan.count;

    // step through columns, rows, tiles, tile rows
    last = 1'b0;
    if (scan.col_in == TILE_W'(TILE_SIZE - 1)) begin
      scan.col_in = '0;
      if (scan.row_in == TILE_W'(TILE_SIZE - 1)) begin
        scan.row_in = '0;
        if (int'(scan.tile_col) + TILE_SIZE >= FRAME_W) begin
          scan.tile_col = '0;
          if (int'(scan.tile_row) + TILE_SIZE >= FRAME_H) begin
            scan.tile_row = '0;
            last = 1'b1;
          end else begin
            scan.tile_row = scan.tile_row + 9'(TILE_SIZE);
          end
        end else begin
          scan.tile_col = scan.tile_col + 10'(TILE_SIZE);
        end
      end else begin
        scan.row_in = scan.row_in + 1'b1;
      end
    end else begin
      scan.col_in = scan.col_in + 1'b1;
    end
    r.frame_last = last;
    scan.count   = scan.count + 1'b1;
    if (last) scan.active = 1'b0;
    return 1'b1;
  endfunction

  // Present one word until accepted, then queue what it should produce
  task automatic send_word(input in_word_t w, input bit typed, input bit typed_has,
                           input out_word_t typed_res);
    out_word_t r;
    bit        has;
    push    <= 1'b1;
    in_word <= w;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    has = scan_position(w, r);
    if (typed) begin
      has = typed_has;
      r   = typed_res;
    end
    if (has) pending_positions.push_back(r);
    if (has || w.opcode == OP_START) counted++;
  endtask

  task automatic send_random(input op_e op);
    send_word(make_word(op, 16'($urandom)), 1'b0, 1'b0, '0);
  endtask

  task automatic pause_sender(input int unsigned n);
    if (n != 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Hold off until every expected word is out and the pipeline is quiet
  task automatic drain_results();
    push <= 1'b0;
    while (pending_positions.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    shadow_write(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Structured value most of the time, a raw 23-bit word now and then
  task automatic write_field(input cfg_idx_e idx, input int unsigned v);
    if ($urandom_range(0, 9) == 0) v = $urandom_range(0, (1 << CFG_DATA_W) - 1);
    write_reg(idx, CFG_DATA_W'(v));
  endtask

  task automatic set_window(input int unsigned hs, input int unsigned he,
                            input int unsigned vs, input int unsigned ve);
    write_field(CFG_H_START, hs);
    write_field(CFG_H_END, he);
    write_field(CFG_V_START, vs);
    write_field(CFG_V_END, ve);
  endtask

  // New register setting between random bursts
  task automatic shuffle_regs(input bit all_regs);
    int unsigned dx;
    int unsigned dy;
    int unsigned hs;
    int unsigned vs;
    int unsigned lw;
    drain_results();
    if (all_regs || $urandom_range(0, 2) == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        set_window($urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom_range(0, 1023), $urandom_range(0, 1023));
      end else begin
        // margins close to zero so the top-left window edges get hit
        dx = $urandom_range(600, 660);
        dy = $urandom_range(440, 500);
        hs = $urandom_range(0, 1023 - dx);
        vs = $urandom_range(0, 1023 - dy);
        set_window(hs, hs + dx, vs, vs + dy);
      end
    end
    if (all_regs || $urandom_range(0, 2) == 0) write_field(CFG_X_STEP, pick(4095));
    if (all_regs || $urandom_range(0, 2) == 0) write_field(CFG_Y_STEP, pick(4095));
    if (all_regs || $urandom_range(0, 2) == 0) write_field(CFG_ORIGIN, pick(23'h7FFFFF));
    if (all_regs || $urandom_range(0, 2) == 0) begin
      if ($urandom_range(0, 9) == 0) lw = 0;
      else if ($urandom_range(0, 7) == 0) lw = 4095;
      else lw = $urandom_range(1, 4095);
      write_field(CFG_LINE_W, lw);
    end
  endtask

  task automatic add_write(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] d);
    plan_row_t p;
    p          = '{reg_idx: CFG_H_START, default: '0};
    p.is_write = 1'b1;
    p.reg_idx  = idx;
    p.reg_data = d;
    plan.push_back(p);
  endtask

  task automatic add_word(input op_e op, input logic [PIX_W-1:0] px);
    plan_row_t p;
    p      = '{reg_idx: CFG_H_START, default: '0};
    p.word = make_word(op, px);
    plan.push_back(p);
  endtask

  task automatic add_typed(input op_e op, input logic [PIX_W-1:0] px, input bit has,
                           input logic [INDEX_W-1:0] di, input logic [ADDR_W-1:0] a,
                           input logic b, input logic [PIX_W-1:0] t, input logic l);
    plan_row_t p;
    p                       = '{reg_idx: CFG_H_START, default: '0};
    p.word                  = make_word(op, px);
    p.typed                 = 1'b1;
    p.typed_has             = has;
    p.typed_res.dest_index  = di;
    p.typed_res.src_address = a;
    p.typed_res.blank       = b;
    p.typed_res.texel_out   = t;
    p.typed_res.frame_last  = l;
    plan.push_back(p);
  endtask

  // Receiver: random pop stalls
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (stall_left != 0) begin
      pop <= 1'b0;
      stall_left--;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 6) == 0) stall_left = gap_len();
    end
  end

  // Compare each popped word with the oldest prediction
  always @(posedge clk_i) begin
    out_word_t e;
    if (rst_ni && pop && !empty) begin
      if (pending_positions.size() == 0) begin
        flag_error($sformatf("word with none expected, dest_index %0d",
                             out_word.dest_index));
      end else begin
        e = pending_positions.pop_front();
        if (out_word.dest_index !== e.dest_index)
          flag_error($sformatf("dest_index %0d, want %0d",
                               out_word.dest_index, e.dest_index));
        if (out_word.src_address !== e.src_address)
          flag_error($sformatf("@%0d src_address %h, want %h", e.dest_index,
                               out_word.src_address, e.src_address));
        if (out_word.blank !== e.blank)
          flag_error($sformatf("@%0d blank %b, want %b", e.dest_index,
                               out_word.blank, e.blank));
        if (out_word.texel_out !== e.texel_out)
          flag_error($sformatf("@%0d texel_out %h, want %h", e.dest_index,
                               out_word.texel_out, e.texel_out));
        if (out_word.frame_last !== e.frame_last)
          flag_error($sformatf("@%0d frame_last %b, want %b", e.dest_index,
                               out_word.frame_last, e.frame_last));
      end
    end
  end

  initial begin
    int  n;
    bit  steady;
    bit  first;
    op_e op;

    regs            = '0;
    regs.x_step     = X_STEP_RST;
    regs.y_step_raw = Y_STEP_RST;
    scan            = '{default: '0};

    // Directed plan. Idle cases first: advance before any start, then a start
    // with zero line width.
    add_typed(OP_ADVANCE, 16'hFFFF, 1'b0, '0, '0, 1'b0, '0, 1'b0);
    add_typed(OP_START,   16'h0000, 1'b0, '0, '0, 1'b0, '0, 1'b0);
    add_typed(OP_ADVANCE, 16'h0000, 1'b0, '0, '0, 1'b0, '0, 1'b0);
    // Largest line width and origin; zero window blanks the top-left corner,
    // second position carries the address into bit 23
    add_write(CFG_LINE_W, 23'd4095);
    add_write(CFG_ORIGIN, 23'h7FFFFF);
    add_typed(OP_START,   16'h1234, 1'b0, '0, '0, 1'b0, '0, 1'b0);
    add_typed(OP_ADVANCE, 16'hFFFF, 1'b1, 19'd0, 24'h7FFFFF, 1'b1, 16'h0000, 1'b0);
    add_typed(OP_ADVANCE, 16'h0000, 1'b1, 19'd1, 24'h800001, 1'b1, 16'h0000, 1'b0);
    // Window wider than the output: negative margins, nothing blanked
    add_write(CFG_H_START, 23'd0);
    add_write(CFG_H_END, 23'd1023);
    add_write(CFG_V_START, 23'd0);
    add_write(CFG_V_END, 23'd1023);
    add_write(CFG_X_STEP, 23'd4095);
    add_write(CFG_Y_STEP, 23'd4095);
    add_word(OP_START, 16'h0000);
    add_word(OP_ADVANCE, 16'hFFFF);
    add_word(OP_ADVANCE, 16'h0000);
    add_word(OP_ADVANCE, 16'h8000);
    add_word(OP_ADVANCE, 16'h7FFE);
    // Scale change mid-frame applies at once
    add_write(CFG_X_STEP, 23'd0);
    add_word(OP_ADVANCE, 16'h0001);
    add_word(OP_ADVANCE, 16'hAAAA);
    // Restart mid-frame
    add_word(OP_START, 16'hFFFF);
    add_word(OP_ADVANCE, 16'h5555);
    // Inverted window: margins only move at the next start
    add_write(CFG_H_START, 23'd1023);
    add_write(CFG_H_END, 23'd0);
    add_write(CFG_V_START, 23'd1023);
    add_write(CFG_V_END, 23'd0);
    add_write(CFG_Y_STEP, 23'd0);
    add_word(OP_ADVANCE, 16'h1234);
    add_word(OP_START, 16'h0000);
    add_word(OP_ADVANCE, 16'hFFFF);
    // Zero line width stops frames again
    add_write(CFG_LINE_W, 23'd0);
    add_typed(OP_START,   16'h0000, 1'b0, '0, '0, 1'b0, '0, 1'b0);
    add_typed(OP_ADVANCE, 16'hFFFF, 1'b0, '0, '0, 1'b0, '0, 1'b0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        if (i == 0 || !plan[i-1].is_write) drain_results();
        write_reg(plan[i].reg_idx, plan[i].reg_data);
      end else begin
        send_word(plan[i].word, plan[i].typed, plan[i].typed_has, plan[i].typed_res);
        pause_sender(gap_len());
      end
    end

    // Random bursts, each after a fresh register setting
    counted    = 0;
    first      = 1'b1;
    while (counted < RANDOM_WORDS) begin
      shuffle_regs(first);
      first = 1'b0;
      if ($urandom_range(0, 9) != 0) send_random(OP_START);
      n      = $urandom_range(4, 120);
      steady = ($urandom_range(0, 3) == 0);
      repeat (n) begin
        op = ($urandom_range(0, 39) == 0) ? OP_START : OP_ADVANCE;
        send_random(op);
        if (!steady) pause_sender(gap_len());
      end
    end

    drain_results();
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
